@@ sv/i2c_master_bit_engine_assert.svh @@
// assertion macros for the i2c master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define I2CMB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define I2CMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define I2CMB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define I2CMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/i2cmb_pkg.sv @@
// types, constants and phase codes shared by the i2c master bit engine
package i2cmb_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;

    localparam logic [5:0] BYTE_STEPS = 6'(4 * BITS_PER_BYTE);
    localparam logic [5:0] LEN_WRITE  = 6'(4 * BITS_PER_BYTE + 5);
    localparam logic [5:0] LEN_READ   = 6'(4 * BITS_PER_BYTE + 4);
    localparam logic [5:0] LEN_SHORT  = 6'd4;

    localparam logic [2:0]  BIT_MSB       = 3'(BITS_PER_BYTE - 1);
    localparam logic [15:0] QUARTER_RESET = 16'd125;

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_RESTART = 3'd1,
        REQ_STOP    = 3'd2,
        REQ_WRITE   = 3'd3,
        REQ_READ    = 3'd4,
        REQ_ACK     = 3'd5,
        REQ_NACK    = 3'd6
    } t_req;

    // quarter within one bit time
    typedef enum logic [1:0] {
        PH_FALL  = 2'd0,
        PH_SETUP = 2'd1,
        PH_RISE  = 2'd2,
        PH_HOLD  = 2'd3
    } t_phase;

    typedef struct packed {
        t_req       op;
        logic [5:0] step;
        logic [7:0] shift;
        logic [7:0] rx;
        logic       scl;
        logic       sda;
        logic       ack;
    } t_phase_ctx;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       ack;
        logic [7:0] rx;
        logic       finish;
    } t_phase_res;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       ack;
        logic [7:0] rx;
    } t_result;

endpackage

@@ sv/i2cmb_if.sv @@
// command and result channels of the i2c master bit engine
interface i2cmb_in_if
    import i2cmb_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, cmd_valid, req_type, tx_byte, sda_in, input ready);
    modport sink   (input valid, cmd_valid, req_type, tx_byte, sda_in, output ready);
endinterface

interface i2cmb_out_if
    import i2cmb_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_bit;
    logic [7:0] rx_byte;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, ack_bit, rx_byte,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, ack_bit, rx_byte,
                    output ready);
endinterface

@@ sv/i2cmb_phase.sv @@
// line changes of one sequencer phase and end-of-sequence detection
module i2cmb_phase
    import i2cmb_pkg::*;
(
    input  t_phase_ctx i_ctx,
    input  logic       i_sda_in,
    output t_phase_res o_res
);

    t_phase     ph;
    logic [2:0] bit_idx;
    logic [5:0] seq_len;
    logic       past_end;
    logic       in_byte;
    logic       hold;

    assign ph      = t_phase'(i_ctx.step[1:0]);
    assign bit_idx = BIT_MSB - i_ctx.step[4:2];
    assign in_byte = i_ctx.step < BYTE_STEPS;

    always_comb begin
        case (i_ctx.op)
            REQ_WRITE: seq_len = LEN_WRITE;
            REQ_READ:  seq_len = LEN_READ;
            default:   seq_len = LEN_SHORT;
        endcase
    end

    assign past_end = i_ctx.step >= seq_len;

    always_comb begin
        o_res.scl = i_ctx.scl;
        o_res.sda = i_ctx.sda;
        o_res.ack = i_ctx.ack;
        o_res.rx  = i_ctx.rx;
        hold      = 1'b1;
        if (!past_end) begin
            case (i_ctx.op)
                REQ_START: begin
                    if (ph == PH_FALL) begin
                        o_res.scl = 1'b1;
                        o_res.sda = 1'b1;
                    end else if (ph == PH_RISE) begin
                        o_res.sda = 1'b0;
                    end
                end
                REQ_RESTART: begin
                    case (ph)
                        PH_FALL:  o_res.scl = 1'b0;
                        PH_SETUP: o_res.sda = 1'b1;
                        PH_RISE:  o_res.scl = 1'b1;
                        PH_HOLD:  o_res.sda = 1'b0;
                        default:  o_res.scl = i_ctx.scl;
                    endcase
                end
                REQ_STOP: begin
                    case (ph)
                        PH_FALL:  o_res.scl = 1'b0;
                        PH_SETUP: o_res.sda = 1'b0;
                        PH_RISE:  o_res.scl = 1'b1;
                        PH_HOLD: begin
                            o_res.sda = 1'b1;
                            hold      = 1'b0;
                        end
                        default:  o_res.scl = i_ctx.scl;
                    endcase
                end
                REQ_WRITE: begin
                    if (in_byte) begin
                        if (ph == PH_FALL) begin
                            o_res.scl = 1'b0;
                        end else if (ph == PH_SETUP) begin
                            o_res.sda = i_ctx.shift[bit_idx];
                        end else if (ph == PH_RISE) begin
                            o_res.scl = 1'b1;
                        end
                    end else if (i_ctx.step == BYTE_STEPS) begin
                        o_res.scl = 1'b0;
                        o_res.sda = 1'b1;
                    end else if (i_ctx.step == BYTE_STEPS + 6'd2) begin
                        o_res.scl = 1'b1;
                    end else if (i_ctx.step == BYTE_STEPS + 6'd4) begin
                        // ack sample, sequence ends on this tick
                        o_res.ack = i_sda_in;
                        hold      = 1'b0;
                    end
                end
                REQ_READ: begin
                    if (ph == PH_FALL) begin
                        o_res.scl = 1'b0;
                        if (in_byte) begin
                            o_res.sda = 1'b1;
                        end
                    end else if (ph == PH_SETUP) begin
                        if (!in_byte) begin
                            o_res.sda = 1'b1;
                        end
                    end else if (ph == PH_RISE) begin
                        o_res.scl = 1'b1;
                    end else if (in_byte) begin
                        o_res.rx[bit_idx] = i_ctx.rx[bit_idx] | i_sda_in;
                    end
                end
                default: begin
                    // ack or nack
                    if (ph == PH_FALL) begin
                        o_res.scl = 1'b0;
                    end else if (ph == PH_SETUP) begin
                        o_res.sda = (i_ctx.op != REQ_ACK);
                    end else if (ph == PH_RISE) begin
                        o_res.scl = 1'b1;
                    end
                end
            endcase
        end
        // a no-wait phase is always the last of its sequence
        o_res.finish = past_end || !hold;
    end

endmodule

@@ sv/i2c_master_bit_engine.sv @@
// i2c master bit engine top level: tick sequencer state and result register
//
//  channel   dir  handshake          payload
//  i_cmd     in   valid/ready        cmd_valid, req_type, tx_byte, sda_in
//  o_res     out  valid/ready        scl_out, sda_out, busy_res, done_res, ack_bit, rx_byte
//  cfg       in   i_cfg_we           i_cfg_wdata (quarter length in ticks)
//
// one tick per cycle while i_cmd.ready is high; each accepted tick gives its result in the next cycle
// the state update and the phase decode sit between the tick input and the result register
// i_cmd.ready stays high while the result register is empty or being drained
// a stalled result holds the sequencer, since no tick is taken
// synchronous active-low reset releases both lines and clears the sequencer
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine
    import i2cmb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    i2cmb_in_if.sink      i_cmd,
    i2cmb_out_if.source   o_res
);

    logic [15:0] r_quarter;
    t_req        r_op,    n_op;
    logic [5:0]  r_step,  n_step;
    logic [15:0] r_tick,  n_tick;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_rx,    n_rx;
    logic        r_scl,   n_scl;
    logic        r_sda,   n_sda;
    logic        r_ack,   n_ack;
    logic        r_busy,  n_busy;
    logic        n_done;
    logic        r_ovalid, n_ovalid;
    t_result     r_res,   n_res;

    logic        acc;
    logic        begin_seq;
    logic        run;
    logic [15:0] quarter_eff;
    t_req        req;
    t_phase_ctx  ctx;
    t_phase_res  ph_res;

    assign i_cmd.ready = !r_ovalid || o_res.ready;
    assign acc         = i_cmd.valid && i_cmd.ready;

    assign req         = t_req'(i_cmd.req_type);
    assign begin_seq   = !r_busy && i_cmd.cmd_valid && (req <= REQ_NACK);
    assign run         = r_busy ? (r_tick <= 16'd1) : begin_seq;
    assign quarter_eff = (r_quarter == '0) ? 16'd1 : r_quarter;

    always_comb begin
        ctx.op    = r_busy ? r_op : req;
        ctx.step  = r_busy ? r_step : '0;
        ctx.shift = (!r_busy && req == REQ_WRITE) ? i_cmd.tx_byte : r_shift;
        ctx.rx    = (!r_busy && req == REQ_READ) ? '0 : r_rx;
        ctx.scl   = r_scl;
        ctx.sda   = r_sda;
        ctx.ack   = r_ack;
    end

    i2cmb_phase u_phase (
        .i_ctx    (ctx),
        .i_sda_in (i_cmd.sda_in),
        .o_res    (ph_res)
    );

    always_comb begin
        n_op    = r_op;
        n_step  = r_step;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_rx    = r_rx;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (acc) begin
            if (run) begin
                n_op    = ctx.op;
                n_shift = ctx.shift;
                n_scl   = ph_res.scl;
                n_sda   = ph_res.sda;
                n_ack   = ph_res.ack;
                n_rx    = ph_res.rx;
                if (ph_res.finish) begin
                    n_busy = 1'b0;
                    n_step = '0;
                    n_tick = '0;
                    n_done = 1'b1;
                end else begin
                    n_busy = 1'b1;
                    n_step = ctx.step + 6'd1;
                    n_tick = quarter_eff;
                end
            end else if (r_busy) begin
                n_tick = r_tick - 16'd1;
            end
        end
    end

    always_comb begin
        n_res.scl  = n_scl;
        n_res.sda  = n_sda;
        n_res.busy = n_busy;
        n_res.done = n_done;
        n_res.ack  = n_ack;
        n_res.rx   = n_rx;
        if (acc) begin
            n_ovalid = 1'b1;
        end else if (o_res.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter <= QUARTER_RESET;
            r_op      <= REQ_START;
            r_step    <= '0;
            r_tick    <= '0;
            r_shift   <= '0;
            r_rx      <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_ack     <= 1'b1;
            r_busy    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quarter <= i_cfg_wdata;
            end
            r_op     <= n_op;
            r_step   <= n_step;
            r_tick   <= n_tick;
            r_shift  <= n_shift;
            r_rx     <= n_rx;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_ack    <= n_ack;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid    = r_ovalid;
    assign o_res.scl_out  = r_res.scl;
    assign o_res.sda_out  = r_res.sda;
    assign o_res.busy_res = r_res.busy;
    assign o_res.done_res = r_res.done;
    assign o_res.ack_bit  = r_res.ack;
    assign o_res.rx_byte  = r_res.rx;

    `I2CMB_ASSERT_NOW(a_busy_has_wait, i_clk, i_rst_n, r_busy, r_tick != '0, "busy with no wait")
    `I2CMB_ASSERT_NOW(a_step_bound, i_clk, i_rst_n, 1'b1, r_step <= LEN_WRITE, "step out of range")
    `I2CMB_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, o_res.valid && o_res.done_res, !o_res.busy_res, "done while busy")
    `I2CMB_ASSERT_NEXT(a_tick_count_down, i_clk, i_rst_n, acc && r_busy && r_tick > 16'd1, r_tick == $past(r_tick) - 16'd1, "wait counter skipped")

endmodule
